### design/bdh_pkg.sv
package bdh_pkg;

  // field widths
  localparam int PIN_W   = 8;
  localparam int MODE_W  = 3;
  localparam int KIND_W  = 3;
  localparam int TICK_W  = 16;
  localparam int CNT_W   = 18;
  localparam int CFG_IDX_W = 1;

  // stream widths, tdata padded to whole bytes
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 5;
  localparam int M_TDATA_W = 8;
  localparam int M_TUSER_W = 3;

  // default table depth
  localparam int PIN_COUNT_DEFAULT = 256;

  // register reset values
  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd10;
  localparam logic [TICK_W-1:0] HOLD_RESET     = 16'd100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 1'b1;

  // edge modes
  localparam logic [MODE_W-1:0] MODE_RELEASE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PRESS       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD        = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHIFT_PRESS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHIFT_HOLD  = 3'd4;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HOLD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REPEAT  = 3'd4;

  typedef logic signed [CNT_W-1:0] cnt_t;
  typedef logic [KIND_W-1:0] kind_t;

endpackage

### design/button_debounce_hold_detector.sv
// channel  dir  tdata (low bit up)         tuser (low bit up)
// s_*      in   pin_index[7:0], pin_level  edge_mode[2:0], repeat_on_hold, shift_active
// m_*      out  event_pin[7:0]             event_kind[2:0]
// cfg_*    in   index 0 debounce_ticks, index 1 hold_ticks, 16-bit write data
//
// one sample per cycle while m_tready is high and no clearing pass runs; each sample goes
// from accept through the counter memory read, then update and write back into the output register.
// a write to the same pin in the cycle of a read is forwarded from a last-write register.
// after reset the counter memory is cleared one entry a cycle, all PIN_COUNT entries,
// during which s_tready is low; configuration writes are taken throughout.
// a stalled m_tready holds the result and the sample in flight, and, outside the clearing
// pass, s_tready drops only when both are full.
module button_debounce_hold_detector
  import bdh_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // pin_index[7:0], pin_level, zero pad
  input  logic [S_TUSER_W-1:0] s_tuser,   // edge_mode[2:0], repeat_on_hold, shift_active
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // event_pin[7:0]
  output logic [M_TUSER_W-1:0] m_tuser,   // event_kind[2:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  // configuration registers
  logic [TICK_W-1:0] debounce_ticks;
  logic [TICK_W-1:0] hold_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      hold_ticks     <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ticks <= cfg_wdata;
        REG_HOLD:     hold_ticks     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input unpacking
  logic [PIN_W-1:0] in_pin;
  logic [IDX_W-1:0] in_idx;
  logic             in_accept;

  assign in_pin    = s_tdata[PIN_W-1:0];
  assign in_idx    = IDX_W'({{IDX_W{1'b0}}, in_pin});
  assign in_accept = s_tvalid && s_tready;

  // clearing pass
  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == IDX_W'(PIN_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // update stage registers
  logic              s1_valid;
  logic [PIN_W-1:0]  s1_pin;
  logic              s1_level;
  logic [MODE_W-1:0] s1_mode;
  logic              s1_repeat;
  logic              s1_shift;
  cnt_t              rd_data;

  logic s1_adv;
  logic s1_fire;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && s1_adv;
  assign s_tready = !clearing && (!s1_valid || s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pin    <= in_pin;
      s1_level  <= s_tdata[PIN_W];
      s1_mode   <= s_tuser[MODE_W-1:0];
      s1_repeat <= s_tuser[MODE_W];
      s1_shift  <= s_tuser[MODE_W+1];
    end
  end

  // counter memory and last-write forwarding
  cnt_t             mem [PIN_COUNT];
  logic             fwd_valid;
  logic [IDX_W-1:0] fwd_idx;
  cnt_t             fwd_data;

  logic [IDX_W-1:0] s1_idx;
  logic             s1_in_range;
  logic             s1_wr;
  cnt_t             c_cur;
  cnt_t             c_next;
  kind_t            kind;

  assign s1_idx      = IDX_W'({{IDX_W{1'b0}}, s1_pin});
  assign s1_in_range = {24'd0, s1_pin} < 32'(PIN_COUNT);
  assign s1_wr       = s1_fire && s1_in_range;
  assign c_cur       = (fwd_valid && fwd_idx == s1_idx) ? fwd_data : rd_data;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (s1_wr) begin
      mem[s1_idx] <= c_next;
    end
    if (in_accept) begin
      rd_data <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      fwd_valid <= 1'b0;
    end else if (s1_wr) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      fwd_idx  <= s1_idx;
      fwd_data <= c_next;
    end
  end

  // phase update and event selection
  cnt_t deb_s;
  cnt_t hold_s;
  logic press_sel;
  logic hold_sel;
  logic release_sel;

  assign deb_s       = $signed({2'b00, debounce_ticks});
  assign hold_s      = $signed({2'b00, hold_ticks});
  assign press_sel   = (!s1_shift && s1_mode == MODE_PRESS) ||
                       (s1_shift && s1_mode == MODE_SHIFT_PRESS);
  assign hold_sel    = (!s1_shift && s1_mode == MODE_HOLD) ||
                       (s1_shift && s1_mode == MODE_SHIFT_HOLD);
  assign release_sel = (s1_mode == MODE_RELEASE);

  always_comb begin
    kind   = KIND_NONE;
    c_next = c_cur;
    if (c_cur == '0) begin
      // idle, waiting for a press
      if (s1_level) begin
        if (press_sel) kind = KIND_PRESS;
        c_next = 18'sd1;
      end
    end else if (c_cur > 18'sd0 && c_cur < deb_s) begin
      // press debounce
      c_next = c_cur + 18'sd1;
    end else if (c_cur >= deb_s && c_cur < hold_s) begin
      // pressed, before hold
      if (!s1_level) begin
        if (release_sel) kind = KIND_RELEASE;
        c_next = -deb_s;
      end else begin
        c_next = c_cur + 18'sd1;
      end
    end else if (c_cur == hold_s) begin
      // hold reached
      if (hold_sel) kind = KIND_HOLD;
      c_next = c_cur + 18'sd1;
    end else if (c_cur > hold_s) begin
      // after hold
      if (s1_level) begin
        if (s1_repeat && hold_sel) kind = KIND_REPEAT;
      end else begin
        if (release_sel) kind = KIND_RELEASE;
        c_next = -deb_s;
      end
    end else begin
      // release debounce
      c_next = c_cur + 18'sd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= s1_pin;
      m_tuser <= s1_in_range ? kind : KIND_NONE;
    end
  end

  // checks
  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !(clearing && (s1_valid || in_accept)))
    else $error("sample in flight during clearing pass");

  a_event_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_NONE |-> {24'd0, m_tdata} < 32'(PIN_COUNT))
    else $error("event reported for pin beyond table");

  a_counter_bounds: assert property (@(posedge clk) disable iff (rst)
    s1_wr |-> c_next >= -18'sd65535 && c_next <= 18'sd65536)
    else $error("phase counter out of range");

  a_release_rearm: assert property (@(posedge clk) disable iff (rst)
    s1_fire && kind == KIND_RELEASE |-> c_next == -deb_s)
    else $error("release did not start release debounce");

  a_forward_after_write: assert property (@(posedge clk) disable iff (rst)
    s1_wr |=> fwd_valid && fwd_data == $past(c_next))
    else $error("last-write register missed a write");

endmodule
